FILE: rtl/gst_pkg.sv
package gst_pkg;

    // Fixed field widths of the request, response and capacity ports
    localparam int REQ_W       = 3;
    localparam int IDX_W       = 8;
    localparam int GRP_IO_W    = 6;
    localparam int CNT_W       = 9;
    localparam int SIZE_IO_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 8;
    localparam int CAP_W       = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Defaults for the top-level parameters
    localparam int MAX_SLOTS_DEF  = 256;
    localparam int GROUP_BITS_DEF = 6;
    localparam int SIZE_BITS_DEF  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_FIND     = 3'd1,
        REQ_COMMIT   = 3'd2,
        REQ_RELEASE  = 3'd3,
        REQ_SET_SIZE = 3'd4,
        REQ_READ     = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    latch_req;   // capture request fields
        logic    clr_res;     // zero result fields, status ok
        logic    set_status;  // load status below
        t_status status;
        logic    idx_inuse;   // result index from fill level
        logic    idx_ptr;     // result index from scan pointer
        logic    ptr_idx;     // pointer from request index
        logic    ptr_inuse;   // pointer from fill level, position to zero
        logic    ptr_inc;     // advance pointer and position
        logic    rd_next;     // read address is pointer plus one, else request index
        logic    wr_ins;      // write a fresh slot at the pointer
        logic    wr_commit;   // write committed flag at request index
        logic    commit_val;
        logic    wr_size;     // write used size at request index
        logic    grow;        // bump fill level by request count
        logic    cap_read;    // result fields from read data
        logic    load_out;    // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_req req;
        logic fits;
        logic cnt_zero;
        logic in_range;
        logic ins_last;
        logic grp_match;
        logic committed;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/gst_ctrl.sv
module gst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gst_pkg::t_stat i_stat,
    output gst_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_INS    = 6'b000100,
        S_SCAN   = 6'b001000,
        S_RDW    = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.clr_res = 1'b1;
                n_state       = S_FIN;
                case (i_stat.req)
                    gst_pkg::REQ_INSERT: begin
                        if (!i_stat.fits) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = gst_pkg::ST_NONE;
                        end else begin
                            o_cmd.idx_inuse = 1'b1;
                            if (!i_stat.cnt_zero) begin
                                o_cmd.ptr_inuse = 1'b1;
                                n_state         = S_INS;
                            end
                        end
                    end
                    gst_pkg::REQ_FIND: begin
                        if (!i_stat.in_range) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = gst_pkg::ST_NONE;
                        end else begin
                            o_cmd.ptr_idx = 1'b1;
                            n_state       = S_SCAN;
                        end
                    end
                    gst_pkg::REQ_COMMIT, gst_pkg::REQ_RELEASE: begin
                        if (!i_stat.in_range) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = gst_pkg::ST_RANGE;
                        end else begin
                            o_cmd.wr_commit  = 1'b1;
                            o_cmd.commit_val = (i_stat.req == gst_pkg::REQ_COMMIT);
                        end
                    end
                    gst_pkg::REQ_SET_SIZE: begin
                        if (!i_stat.in_range) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = gst_pkg::ST_RANGE;
                        end else begin
                            o_cmd.wr_size = 1'b1;
                        end
                    end
                    gst_pkg::REQ_READ: begin
                        if (!i_stat.in_range) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = gst_pkg::ST_RANGE;
                        end else begin
                            n_state = S_RDW;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_INS: begin
                o_cmd.wr_ins  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_stat.ins_last) begin
                    o_cmd.grow = 1'b1;
                    n_state    = S_FIN;
                end
            end
            S_SCAN: begin
                // read data here belongs to the pointer; prefetch the next slot
                o_cmd.rd_next = 1'b1;
                if (!i_stat.grp_match) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = gst_pkg::ST_NONE;
                    n_state          = S_FIN;
                end else if (!i_stat.committed) begin
                    o_cmd.idx_ptr = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = gst_pkg::ST_NONE;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_RDW: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/gst_datapath.sv
module gst_datapath #(
    parameter int MAX_SLOTS  = gst_pkg::MAX_SLOTS_DEF,
    parameter int GROUP_BITS = gst_pkg::GROUP_BITS_DEF,
    parameter int SIZE_BITS  = gst_pkg::SIZE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gst_pkg::REQ_W-1:0]       i_req_type,
    input  logic [gst_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [gst_pkg::GRP_IO_W-1:0]    i_group_id,
    input  logic [gst_pkg::CNT_W-1:0]       i_slot_count,
    input  logic [gst_pkg::SIZE_IO_W-1:0]   i_size_value,
    input  logic                            i_cfg_we,
    input  logic [gst_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [gst_pkg::STATUS_W-1:0]    o_status,
    output logic [gst_pkg::IDX_W-1:0]       o_result_index,
    output logic                            o_committed_out,
    output logic [gst_pkg::GRP_IO_W-1:0]    o_group_id_out,
    output logic [gst_pkg::SIZE_IO_W-1:0]   o_size_used_out,
    output logic [gst_pkg::POS_W-1:0]       o_position_out,
    input  gst_pkg::t_cmd                   i_cmd,
    output gst_pkg::t_stat                  o_stat
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int UW = $clog2(MAX_SLOTS + 1);
    localparam int EW = ((UW > gst_pkg::CAP_W) ? UW : gst_pkg::CAP_W) + 1;

    // Request fields
    logic [gst_pkg::REQ_W-1:0]  r_req;
    logic [gst_pkg::IDX_W-1:0]  r_idx;
    logic [GROUP_BITS-1:0]      r_grp;
    logic [gst_pkg::CNT_W-1:0]  r_cnt;
    logic [SIZE_BITS-1:0]       r_size;

    logic [gst_pkg::CAP_W-1:0]  r_cap;
    logic [UW-1:0]              r_in_use;
    logic [UW-1:0]              r_ptr;
    logic [gst_pkg::POS_W-1:0]  r_pos;

    // Slot storage
    logic                       mem_comm [MAX_SLOTS];
    logic [GROUP_BITS-1:0]      mem_grp  [MAX_SLOTS];
    logic [SIZE_BITS-1:0]       mem_size [MAX_SLOTS];
    logic [gst_pkg::POS_W-1:0]  mem_pos  [MAX_SLOTS];

    logic                       r_rd_comm;
    logic [GROUP_BITS-1:0]      r_rd_grp;
    logic [SIZE_BITS-1:0]       r_rd_size;
    logic [gst_pkg::POS_W-1:0]  r_rd_pos;

    // Pending result
    gst_pkg::t_status           r_res_status;
    logic [gst_pkg::IDX_W-1:0]  r_res_index;
    logic                       r_res_comm;
    logic [gst_pkg::GRP_IO_W-1:0]  r_res_grp;
    logic [gst_pkg::SIZE_IO_W-1:0] r_res_size;
    logic [gst_pkg::POS_W-1:0]  r_res_pos;

    logic [EW-1:0]              end_sum;
    logic [EW-1:0]              eff_cap;
    logic [UW:0]                ptr_p1;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       we_comm;
    logic                       wd_comm;
    logic                       we_size;
    logic [SIZE_BITS-1:0]       wd_size;

    assign end_sum = EW'(r_in_use) + EW'(r_cnt);
    assign eff_cap = (EW'(r_cap) > EW'(MAX_SLOTS)) ? EW'(MAX_SLOTS) : EW'(r_cap);
    assign ptr_p1  = {1'b0, r_ptr} + (UW+1)'(1);

    assign rd_addr = i_cmd.rd_next ? AW'(ptr_p1) : AW'(r_idx);
    assign wr_addr = i_cmd.wr_ins ? AW'(r_ptr) : AW'(r_idx);
    assign we_comm = i_cmd.wr_ins | i_cmd.wr_commit;
    assign wd_comm = i_cmd.wr_commit & i_cmd.commit_val;
    assign we_size = i_cmd.wr_ins | i_cmd.wr_size;
    assign wd_size = i_cmd.wr_size ? r_size : '0;

    always_comb begin
        o_stat.req       = gst_pkg::t_req'(r_req);
        o_stat.fits      = (end_sum <= eff_cap);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.in_range  = (EW'(r_idx) < EW'(r_in_use));
        o_stat.ins_last  = (EW'(ptr_p1) == end_sum);
        o_stat.grp_match = (r_rd_grp == r_grp);
        o_stat.committed = r_rd_comm;
        o_stat.scan_last = (ptr_p1 >= {1'b0, r_in_use});
        o_stat.out_free  = ~o_valid | ~i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req  <= i_req_type;
            r_idx  <= i_slot_index;
            r_grp  <= GROUP_BITS'(i_group_id);
            r_cnt  <= i_slot_count;
            r_size <= SIZE_BITS'(i_size_value);
        end
        if (i_cmd.ptr_idx) begin
            r_ptr <= UW'(r_idx);
        end else if (i_cmd.ptr_inuse) begin
            r_ptr <= r_in_use;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= ptr_p1[UW-1:0];
        end
        if (i_cmd.ptr_inuse) begin
            r_pos <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_pos <= r_pos + gst_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= gst_pkg::CAP_RESET;
            r_in_use <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.grow) begin
                r_in_use <= end_sum[UW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_comm) begin
            mem_comm[wr_addr] <= wd_comm;
        end
        r_rd_comm <= mem_comm[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ins) begin
            mem_grp[wr_addr] <= r_grp;
        end
        r_rd_grp <= mem_grp[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_size) begin
            mem_size[wr_addr] <= wd_size;
        end
        r_rd_size <= mem_size[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ins) begin
            mem_pos[wr_addr] <= r_pos;
        end
        r_rd_pos <= mem_pos[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_res) begin
            r_res_status <= gst_pkg::ST_OK;
            r_res_index  <= '0;
            r_res_comm   <= 1'b0;
            r_res_grp    <= '0;
            r_res_size   <= '0;
            r_res_pos    <= '0;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.idx_inuse) begin
            r_res_index <= gst_pkg::IDX_W'(r_in_use);
        end
        if (i_cmd.idx_ptr) begin
            r_res_index <= gst_pkg::IDX_W'(r_ptr);
        end
        if (i_cmd.cap_read) begin
            r_res_comm <= r_rd_comm;
            r_res_grp  <= gst_pkg::GRP_IO_W'(r_rd_grp);
            r_res_size <= gst_pkg::SIZE_IO_W'(r_rd_size);
            r_res_pos  <= r_rd_pos;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status        <= r_res_status;
            o_result_index  <= r_res_index;
            o_committed_out <= r_res_comm;
            o_group_id_out  <= r_res_grp;
            o_size_used_out <= r_res_size;
            o_position_out  <= r_res_pos;
        end
    end

endmodule

FILE: rtl/grouped_slot_table_top.sv
// Grouped slot table: a bump-allocated table of up to MAX_SLOTS slots, each
// tagged with an owner group, a committed flag, a used size and its position
// within the run it was appended in. One request gives one response. Insert
// writes one slot per cycle through the single memory write port, and writes
// none when slot_count is zero or the run does not fit; find_free compares
// one slot per cycle, read ahead through the registered memory read port,
// and compares none when the start is past the fill level; read_slot waits
// in a read state for the memory data, which commit, release, set_size and
// unknown codes do not. One request is in flight at a time: o_stall stays
// high from acceptance until its response is loaded into the output register,
// and a new request is accepted while that response still waits under
// i_stall. Slot storage has no reset; only data from slots below the fill
// level is ever used. capacity is written through i_cfg_we/i_cfg_data and
// resets to 256; values above MAX_SLOTS act as MAX_SLOTS.
module grouped_slot_table_top #(
    parameter int MAX_SLOTS  = gst_pkg::MAX_SLOTS_DEF,
    parameter int GROUP_BITS = gst_pkg::GROUP_BITS_DEF,
    parameter int SIZE_BITS  = gst_pkg::SIZE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [gst_pkg::REQ_W-1:0]       i_req_type,
    input  logic [gst_pkg::IDX_W-1:0]       i_slot_index,
    input  logic [gst_pkg::GRP_IO_W-1:0]    i_group_id,
    input  logic [gst_pkg::CNT_W-1:0]       i_slot_count,
    input  logic [gst_pkg::SIZE_IO_W-1:0]   i_size_value,
    // capacity register
    input  logic                            i_cfg_we,
    input  logic [gst_pkg::CAP_W-1:0]       i_cfg_data,
    // response channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [gst_pkg::STATUS_W-1:0]    o_status,
    output logic [gst_pkg::IDX_W-1:0]       o_result_index,
    output logic                            o_committed_out,
    output logic [gst_pkg::GRP_IO_W-1:0]    o_group_id_out,
    output logic [gst_pkg::SIZE_IO_W-1:0]   o_size_used_out,
    output logic [gst_pkg::POS_W-1:0]       o_position_out
);

    // Commands flow from the sequencer, compare flags flow back
    gst_pkg::t_cmd  cmd;
    gst_pkg::t_stat stat;

    gst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Slot memories, fill level, capacity, request and response registers
    gst_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .GROUP_BITS (GROUP_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_slot_index    (i_slot_index),
        .i_group_id      (i_group_id),
        .i_slot_count    (i_slot_count),
        .i_size_value    (i_size_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_result_index  (o_result_index),
        .o_committed_out (o_committed_out),
        .o_group_id_out  (o_group_id_out),
        .o_size_used_out (o_size_used_out),
        .o_position_out  (o_position_out),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

endmodule

FILE: dv/grouped_slot_table_top_tb.sv
`timescale 1ns / 100ps

module grouped_slot_table_top_tb;

    // Request codes outside the defined set; the block answers them with an all-zero response
    localparam logic [gst_pkg::REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [gst_pkg::REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    localparam int TABLE_DEPTH     = gst_pkg::MAX_SLOTS_DEF;
    localparam int HOLD_OFF_CYCLES = 200;   // long response back-pressure stretch
    localparam int WATCHDOG_LIMIT  = 4000;  // far above the longest scan or insert plus hold-off
    localparam int DRAIN_CYCLES    = 16;    // settle time after the last response

    typedef struct packed {
        logic [gst_pkg::REQ_W-1:0]     kind;
        logic [gst_pkg::IDX_W-1:0]     index;
        logic [gst_pkg::GRP_IO_W-1:0]  group;
        logic [gst_pkg::CNT_W-1:0]     count;
        logic [gst_pkg::SIZE_IO_W-1:0] size;
    } t_slot_req;

    typedef struct packed {
        logic [gst_pkg::STATUS_W-1:0]  status;
        logic [gst_pkg::IDX_W-1:0]     index;
        logic                          committed;
        logic [gst_pkg::GRP_IO_W-1:0]  group;
        logic [gst_pkg::SIZE_IO_W-1:0] size;
        logic [gst_pkg::POS_W-1:0]     position;
    } t_slot_resp;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n         = 1'b0;
    logic                           i_valid         = 1'b0;
    logic                           o_stall;
    logic [gst_pkg::REQ_W-1:0]      i_req_type      = '0;
    logic [gst_pkg::IDX_W-1:0]      i_slot_index    = '0;
    logic [gst_pkg::GRP_IO_W-1:0]   i_group_id      = '0;
    logic [gst_pkg::CNT_W-1:0]      i_slot_count    = '0;
    logic [gst_pkg::SIZE_IO_W-1:0]  i_size_value    = '0;
    logic                           i_cfg_we        = 1'b0;
    logic [gst_pkg::CAP_W-1:0]      i_cfg_data      = '0;
    logic                           o_valid;
    logic                           i_stall         = 1'b0;
    logic [gst_pkg::STATUS_W-1:0]   o_status;
    logic [gst_pkg::IDX_W-1:0]      o_result_index;
    logic                           o_committed_out;
    logic [gst_pkg::GRP_IO_W-1:0]   o_group_id_out;
    logic [gst_pkg::SIZE_IO_W-1:0]  o_size_used_out;
    logic [gst_pkg::POS_W-1:0]      o_position_out;

    grouped_slot_table_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_slot_index    (i_slot_index),
        .i_group_id      (i_group_id),
        .i_slot_count    (i_slot_count),
        .i_size_value    (i_size_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_index  (o_result_index),
        .o_committed_out (o_committed_out),
        .o_group_id_out  (o_group_id_out),
        .o_size_used_out (o_size_used_out),
        .o_position_out  (o_position_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Slot table shadow: our own copy of the table, the fill level and
    // the capacity register, advanced once per accepted request
    // ------------------------------------------------------------------
    logic                           table_committed [TABLE_DEPTH];
    logic [gst_pkg::GRP_IO_W-1:0]   table_group     [TABLE_DEPTH];
    logic [gst_pkg::SIZE_IO_W-1:0]  table_size      [TABLE_DEPTH];
    logic [gst_pkg::POS_W-1:0]      table_position  [TABLE_DEPTH];
    int unsigned           table_fill = 0;
    int unsigned           table_cap  = 32'(gst_pkg::CAP_RESET);

    t_slot_req  req_pending_q [$];     // requests waiting for the driver
    t_slot_resp resp_expected_q [$];   // responses owed by the block, oldest first
    t_slot_req  req_on_bus;

    int unsigned n_accepted = 0, n_insert_placed = 0, n_refused = 0;
    int unsigned n_find_hit = 0, n_range = 0, n_cap_settings = 0;
    int unsigned err_count = 0;

    // Work out the response for one request and advance the shadow table
    task automatic predict_response(input t_slot_req r);
        t_slot_resp  rsp;
        int unsigned cap_eff;
        int unsigned last;
        int unsigned i;
        rsp = '0;
        rsp.status = gst_pkg::ST_OK;
        cap_eff = (table_cap > TABLE_DEPTH) ? TABLE_DEPTH : table_cap;
        n_accepted++;
        case (r.kind)
            gst_pkg::REQ_INSERT: begin
                last = table_fill + 32'(r.count);
                if (last > cap_eff) begin
                    rsp.status = gst_pkg::ST_NONE;
                end else begin
                    for (i = table_fill; i < last; i++) begin
                        table_committed[i] = 1'b0;
                        table_group[i]     = r.group;
                        table_size[i]      = '0;
                        table_position[i]  = gst_pkg::POS_W'(i - table_fill);
                    end
                    rsp.index  = gst_pkg::IDX_W'(table_fill);
                    table_fill = last;
                    n_insert_placed++;
                end
            end
            gst_pkg::REQ_FIND: begin
                // Walk up from the start while the group holds; stop on the first free slot
                rsp.status = gst_pkg::ST_NONE;
                if (32'(r.index) < table_fill) begin
                    for (i = 32'(r.index); i < table_fill; i++) begin
                        if (table_group[i] != r.group)
                            break;
                        if (!table_committed[i]) begin
                            rsp.status = gst_pkg::ST_OK;
                            rsp.index  = gst_pkg::IDX_W'(i);
                            n_find_hit++;
                            break;
                        end
                    end
                end
            end
            gst_pkg::REQ_COMMIT, gst_pkg::REQ_RELEASE, gst_pkg::REQ_SET_SIZE,
            gst_pkg::REQ_READ: begin
                if (32'(r.index) >= table_fill) begin
                    rsp.status = gst_pkg::ST_RANGE;
                    n_range++;
                end else begin
                    case (r.kind)
                        gst_pkg::REQ_COMMIT:   table_committed[r.index] = 1'b1;
                        gst_pkg::REQ_RELEASE:  table_committed[r.index] = 1'b0;
                        gst_pkg::REQ_SET_SIZE: table_size[r.index] = r.size;
                        default: begin
                            rsp.committed = table_committed[r.index];
                            rsp.group     = table_group[r.index];
                            rsp.size      = table_size[r.index];
                            rsp.position  = table_position[r.index];
                        end
                    endcase
                end
            end
            default: ;
        endcase
        if (rsp.status == gst_pkg::ST_NONE)
            n_refused++;
        resp_expected_q.push_back(rsp);
    endtask

    // ------------------------------------------------------------------
    // Request driver: present the next pending request, hold it while
    // stalled, and sometimes idle for a short burst after each one
    // ------------------------------------------------------------------
    int unsigned tx_gap = 0;
    bit          tx_idle_en = 1'b1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && !o_stall)
                predict_response(req_on_bus);
            if (!i_valid || !o_stall) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (req_pending_q.size() != 0) begin
                    req_on_bus = req_pending_q.pop_front();
                    i_valid      <= 1'b1;
                    i_req_type   <= req_on_bus.kind;
                    i_slot_index <= req_on_bus.index;
                    i_group_id   <= req_on_bus.group;
                    i_slot_count <= req_on_bus.count;
                    i_size_value <= req_on_bus.size;
                    if (tx_idle_en && $urandom_range(0, 99) < 15)
                        tx_gap = $urandom_range(1, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: compare each accepted response with the oldest
    // expectation, and drive the response stall (random bursts plus one
    // long hold-off when requested)
    // ------------------------------------------------------------------
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    int unsigned hold_seq = 0, hold_seen = 0;
    bit          rx_idle_en = 1'b1;
    t_slot_resp  resp_want;

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (resp_expected_q.size() == 0) begin
                    err_count++;
                    $display("%0t: response with nothing outstanding, status %0d",
                             $time, o_status);
                end else begin
                    resp_want = resp_expected_q.pop_front();
                    check_field("status",        32'(resp_want.status),
                                32'(o_status));
                    check_field("result_index",  32'(resp_want.index),
                                32'(o_result_index));
                    check_field("committed_out", 32'(resp_want.committed),
                                32'(o_committed_out));
                    check_field("group_id_out",  32'(resp_want.group),
                                32'(o_group_id_out));
                    check_field("size_used_out", resp_want.size, o_size_used_out);
                    check_field("position_out",  32'(resp_want.position),
                                32'(o_position_out));
                end
            end
            // Start a long hold-off when the stimulus asks for one
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 99) < 12) begin
                rx_gap = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles, %0d responses owed",
                     $time, quiet_cycles, resp_expected_q.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: track the fill level and the runs appended so far, so
    // most requests land on live slots and finds start at real groups
    // ------------------------------------------------------------------
    int unsigned gen_fill = 0;
    int unsigned gen_cap  = 32'(gst_pkg::CAP_RESET);
    int unsigned gen_items = 0;
    int unsigned gen_last_grp = 0;
    int unsigned run_start [$];
    int unsigned run_len [$];
    int unsigned run_grp [$];

    task automatic push_req(input logic [gst_pkg::REQ_W-1:0] kind,
                            input logic [gst_pkg::IDX_W-1:0] index,
                            input logic [gst_pkg::GRP_IO_W-1:0] group,
                            input logic [gst_pkg::CNT_W-1:0] count,
                            input logic [gst_pkg::SIZE_IO_W-1:0] size);
        t_slot_req r;
        r.kind  = kind;
        r.index = index;
        r.group = group;
        r.count = count;
        r.size  = size;
        req_pending_q.push_back(r);
        gen_items++;
    endtask

    // Slot operation; fields the operation ignores get random content
    task automatic push_op(input logic [gst_pkg::REQ_W-1:0] kind,
                           input logic [gst_pkg::IDX_W-1:0] index,
                           input logic [gst_pkg::SIZE_IO_W-1:0] size);
        push_req(kind, index, gst_pkg::GRP_IO_W'($urandom_range(0, 63)),
                 gst_pkg::CNT_W'($urandom_range(0, 256)), size);
    endtask

    function automatic int unsigned gen_room();
        int unsigned eff;
        eff = (gen_cap > TABLE_DEPTH) ? TABLE_DEPTH : gen_cap;
        return (eff > gen_fill) ? eff - gen_fill : 0;
    endfunction

    task automatic push_insert(input int unsigned group, input int unsigned count);
        if (count != 0 && count <= gen_room()) begin
            run_start.push_back(gen_fill);
            run_len.push_back(count);
            run_grp.push_back(group);
            gen_fill += count;
            gen_last_grp = group;
        end
        push_req(gst_pkg::REQ_INSERT, gst_pkg::IDX_W'($urandom_range(0, 255)),
                 gst_pkg::GRP_IO_W'(group), gst_pkg::CNT_W'(count), $urandom);
    endtask

    // Mostly a live slot, sometimes the first slot past the end, sometimes anywhere
    function automatic logic [gst_pkg::IDX_W-1:0] pick_slot();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gen_fill != 0 && r < 85)
            return gst_pkg::IDX_W'($urandom_range(0, gen_fill - 1));
        else if (r < 92)
            return gst_pkg::IDX_W'(gen_fill);
        return gst_pkg::IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [gst_pkg::SIZE_IO_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        return $urandom;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        else if (r < 60)
            return $urandom_range(1, 4);
        else if (r < 80)
            return $urandom_range(5, 16);
        else if (r < 90)
            return (gen_room() != 0) ? gen_room() : TABLE_DEPTH;
        return $urandom_range(0, 256);
    endfunction

    // One request of any kind, weighted toward operations on live slots
    task automatic push_random_request();
        int unsigned r, k, g;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            g = (run_grp.size() != 0 && $urandom_range(0, 2) == 0) ?
                gen_last_grp : $urandom_range(0, 63);
            push_insert(g, pick_count());
        end else if (r < 37) begin
            if (run_start.size() != 0 && $urandom_range(0, 99) < 60) begin
                k = $urandom_range(0, run_start.size() - 1);
                push_req(gst_pkg::REQ_FIND,
                         gst_pkg::IDX_W'(run_start[k] + $urandom_range(0, run_len[k] - 1)),
                         gst_pkg::GRP_IO_W'(run_grp[k]),
                         gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
            end else if ($urandom_range(0, 1) == 0) begin
                push_req(gst_pkg::REQ_FIND, pick_slot(),
                         gst_pkg::GRP_IO_W'($urandom_range(0, 63)),
                         gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
            end else begin
                push_req(gst_pkg::REQ_FIND, gst_pkg::IDX_W'($urandom_range(0, 255)),
                         gst_pkg::GRP_IO_W'($urandom_range(0, 63)),
                         gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
            end
        end else if (r < 55) begin
            push_op(gst_pkg::REQ_COMMIT, pick_slot(), $urandom);
        end else if (r < 65) begin
            push_op(gst_pkg::REQ_RELEASE, pick_slot(), $urandom);
        end else if (r < 78) begin
            push_op(gst_pkg::REQ_SET_SIZE, pick_slot(), pick_size());
        end else if (r < 95) begin
            push_op(gst_pkg::REQ_READ, pick_slot(), $urandom);
        end else begin
            push_req(($urandom_range(0, 1) != 0) ? REQ_RSVD_7 : REQ_RSVD_6,
                     gst_pkg::IDX_W'($urandom_range(0, 255)),
                     gst_pkg::GRP_IO_W'($urandom_range(0, 63)),
                     gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
        end
    endtask

    // Typical life of a group: append a run, commit some of it, look for a
    // free slot, at times release one and look again, size a slot, read back
    task automatic push_group_run();
        int unsigned g, n, k, fill_was, slot;
        g = (run_grp.size() != 0 && $urandom_range(0, 3) == 0) ?
            gen_last_grp : $urandom_range(0, 63);
        n = $urandom_range(1, 6);
        fill_was = gen_fill;
        push_insert(g, n);
        if (run_start.size() == 0)
            return;
        // Fall back on an older run when the insert did not fit
        k = (gen_fill != fill_was) ? run_start.size() - 1 : $urandom_range(0, run_start.size() - 1);
        repeat ($urandom_range(0, run_len[k]))
            push_op(gst_pkg::REQ_COMMIT,
                    gst_pkg::IDX_W'(run_start[k] + $urandom_range(0, run_len[k] - 1)),
                    $urandom);
        push_req(gst_pkg::REQ_FIND, gst_pkg::IDX_W'(run_start[k]),
                 gst_pkg::GRP_IO_W'(run_grp[k]),
                 gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
        if ($urandom_range(0, 1) != 0) begin
            push_op(gst_pkg::REQ_RELEASE,
                    gst_pkg::IDX_W'(run_start[k] + $urandom_range(0, run_len[k] - 1)),
                    $urandom);
            push_req(gst_pkg::REQ_FIND, gst_pkg::IDX_W'(run_start[k]),
                     gst_pkg::GRP_IO_W'(run_grp[k]),
                     gst_pkg::CNT_W'($urandom_range(0, 256)), $urandom);
        end
        slot = run_start[k] + $urandom_range(0, run_len[k] - 1);
        push_op(gst_pkg::REQ_SET_SIZE, gst_pkg::IDX_W'(slot), pick_size());
        push_op(gst_pkg::REQ_READ, gst_pkg::IDX_W'(slot), $urandom);
        push_op(gst_pkg::REQ_READ,
                gst_pkg::IDX_W'(run_start[k] + $urandom_range(0, run_len[k] - 1)),
                $urandom);
    endtask

    // Hold the sender until every owed response is back, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_pending_q.size() != 0 || i_valid || resp_expected_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write the capacity register; only called with the block idle
    task automatic write_capacity(input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= gst_pkg::CAP_W'(value);
        table_cap = value;
        gen_cap   = value;
        n_cap_settings++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned cap, input int unsigned items,
                             input bit idle_en, input bit hold_off);
        int unsigned target;
        write_capacity(cap);
        @(negedge i_clk);
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
        target = gen_items + items;
        while (gen_items < target) begin
            if ($urandom_range(0, 99) < 35)
                push_group_run();
            else
                push_random_request();
        end
        // Stall responses for a long stretch while requests keep coming
        if (hold_off)
            hold_seq++;
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, zero-length insert, unknown codes, then a
        // small two-group table to walk the find rules by hand
        push_op(gst_pkg::REQ_READ, 0, $urandom);          // out of range on empty table
        push_op(gst_pkg::REQ_COMMIT, 8'hFF, $urandom);    // out of range, top index
        push_req(gst_pkg::REQ_FIND, 0, 0, 0, 0);          // find start past fill level
        push_insert(5, 0);                                // zero slots: ok, nothing appended
        push_req(REQ_RSVD_6, 8'hFF, 6'h3F, 9'd256, 32'hFFFF_FFFF);
        push_req(REQ_RSVD_7, 0, 0, 0, 0);
        push_insert(63, 3);                               // slots 0..2, group 63
        push_insert(0, 2);                                // slots 3..4, group 0
        push_op(gst_pkg::REQ_READ, 1, $urandom);
        push_op(gst_pkg::REQ_SET_SIZE, 1, 32'hFFFF_FFFF);
        push_op(gst_pkg::REQ_READ, 1, $urandom);
        push_op(gst_pkg::REQ_COMMIT, 0, $urandom);
        push_req(gst_pkg::REQ_FIND, 0, 63, 0, 0);         // skips committed slot 0
        push_op(gst_pkg::REQ_COMMIT, 1, $urandom);
        push_op(gst_pkg::REQ_COMMIT, 2, 0);
        push_req(gst_pkg::REQ_FIND, 0, 63, 0, 0);         // no match: stops at group change
        push_op(gst_pkg::REQ_RELEASE, 1, $urandom);
        push_req(gst_pkg::REQ_FIND, 1, 63, 0, 0);
        push_req(gst_pkg::REQ_FIND, 0, 0, 0, 0);          // group differs at the start
        push_op(gst_pkg::REQ_COMMIT, 4, $urandom);
        push_req(gst_pkg::REQ_FIND, 3, 0, 0, 0);
        push_op(gst_pkg::REQ_COMMIT, 3, $urandom);
        push_req(gst_pkg::REQ_FIND, 3, 0, 0, 0);          // no match: runs into fill level
        push_op(gst_pkg::REQ_READ, 4, $urandom);
        push_op(gst_pkg::REQ_COMMIT, 5, $urandom);        // first index past the end
        push_insert(7, 256);                              // does not fit
        wait_idle();

        // Random phases; the table only grows, so order the capacities to
        // see refusals at zero, partial fills, an oversized setting, a
        // setting below the fill level and finally the full table
        run_phase(0,   120, 1'b1, 1'b0);
        run_phase(40,  280, 1'b1, 1'b1);
        run_phase(130, 300, 1'b1, 1'b0);
        run_phase(511, 300, 1'b1, 1'b0);
        run_phase(200, 250, 1'b1, 1'b0);
        run_phase(256, 400, 1'b0, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d capacity settings, table filled to %0d slots;",
                 n_accepted, n_cap_settings, table_fill);
        $display("%0d inserts placed, %0d finds hit a free slot, %0d refusals, %0d range errors",
                 n_insert_placed, n_find_hit, n_refused, n_range);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: grouped_slot_table_top.f
rtl/gst_pkg.sv
rtl/gst_ctrl.sv
rtl/gst_datapath.sv
rtl/grouped_slot_table_top.sv
dv/grouped_slot_table_top_tb.sv
